[rtl/odp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odp_pkg
// Shared widths, the threshold matrix and the scale bundle of the dither block.
// ----------------------------------------------------------------------------
package odp_pkg;

  localparam int PIX_W   = 8;   // pixel intensity
  localparam int COORD_W = 12;  // column and row
  localparam int LEVEL_W = 9;   // level count register
  localparam int STEP_W  = 8;   // quantizer step, 1..128
  localparam int ENT_W   = 4;   // matrix entry, 0..15
  localparam int SUM_W   = 9;   // pixel plus threshold, up to 375

  // Reciprocal of the step in fixed point with RECIP_SHIFT fraction bits
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // Word width of the shift-subtract divider that derives step and reciprocal
  localparam int DIV_W   = RECIP_W;
  localparam int DIV_CNT = $clog2(DIV_W);

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  // Quantizer scale, held steady except while a configuration write is being processed
  typedef struct packed {
    logic               busy;   // step and reciprocal are being recomputed
    logic [STEP_W-1:0]  step;
    logic [RECIP_W-1:0] recip;  // floor(2^RECIP_SHIFT / step)
  } scale_t;

  // 4x4 Bayer threshold matrix, indexed by the low bits of row and column
  function automatic logic [ENT_W-1:0] bayer_entry(input logic [1:0] row,
                                                   input logic [1:0] col);
    logic [ENT_W-1:0] ent;
    unique case ({row, col})
      4'h0: ent = 4'd0;
      4'h1: ent = 4'd8;
      4'h2: ent = 4'd2;
      4'h3: ent = 4'd10;
      4'h4: ent = 4'd12;
      4'h5: ent = 4'd4;
      4'h6: ent = 4'd14;
      4'h7: ent = 4'd6;
      4'h8: ent = 4'd3;
      4'h9: ent = 4'd11;
      4'hA: ent = 4'd1;
      4'hB: ent = 4'd9;
      4'hC: ent = 4'd15;
      4'hD: ent = 4'd7;
      4'hE: ent = 4'd13;
      default: ent = 4'd5;
    endcase
    return ent;
  endfunction

endpackage

[rtl/odp_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odp_scale
// Level count register; derives step = 256 / level and its reciprocal with a
// one-bit-per-cycle shift-subtract divider after each write.
// ----------------------------------------------------------------------------
module odp_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [odp_pkg::LEVEL_W-1:0]   cfg_data,
  output odp_pkg::scale_t               scale
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_STEP  = 3'b010,
    ST_RECIP = 3'b100
  } div_state_t;

  localparam logic [odp_pkg::DIV_W-1:0]   DVD_STEP  = odp_pkg::DIV_W'(256);
  localparam logic [odp_pkg::DIV_W-1:0]   DVD_RECIP =
    odp_pkg::DIV_W'(1) << odp_pkg::RECIP_SHIFT;
  localparam logic [odp_pkg::LEVEL_W-1:0] LEVEL_MIN = odp_pkg::LEVEL_W'(2);
  localparam logic [odp_pkg::LEVEL_W-1:0] LEVEL_MAX = odp_pkg::LEVEL_W'(256);

  div_state_t                        state;
  logic [odp_pkg::DIV_W-1:0]         dvd;
  logic [odp_pkg::LEVEL_W-1:0]       dsr;
  logic [odp_pkg::LEVEL_W-1:0]       rem;
  logic [odp_pkg::DIV_CNT-1:0]       cnt;
  logic [odp_pkg::STEP_W-1:0]        step;
  logic [odp_pkg::RECIP_W-1:0]       recip;

  logic [odp_pkg::LEVEL_W-1:0]       level_clamped;
  logic [odp_pkg::LEVEL_W:0]         rem_shift;
  logic                              qbit;
  logic [odp_pkg::LEVEL_W-1:0]       rem_next;
  logic [odp_pkg::DIV_W-1:0]         quo_next;

  // Clamp the written level count into 2..256
  always_comb begin
    if (cfg_data < LEVEL_MIN) begin
      level_clamped = LEVEL_MIN;
    end else if (cfg_data > LEVEL_MAX) begin
      level_clamped = LEVEL_MAX;
    end else begin
      level_clamped = cfg_data;
    end
  end

  // One restoring divide step: bring in the next dividend bit, try subtract
  always_comb begin
    rem_shift = {rem, dvd[odp_pkg::DIV_W-1]};
    qbit      = (rem_shift >= {1'b0, dsr});
    rem_next  = qbit ? odp_pkg::LEVEL_W'(rem_shift - {1'b0, dsr})
                     : rem_shift[odp_pkg::LEVEL_W-1:0];
    quo_next  = {dvd[odp_pkg::DIV_W-2:0], qbit};
  end

  // Sequence the two divisions after a write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= odp_pkg::STEP_W'(1);
      recip <= DVD_RECIP;
      dvd   <= '0;
      dsr   <= LEVEL_MAX;
      rem   <= '0;
      cnt   <= '0;
    end else if (cfg_valid) begin
      state <= ST_STEP;
      dvd   <= DVD_STEP;
      dsr   <= level_clamped;
      rem   <= '0;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
        end
        ST_STEP: begin
          if (cnt == odp_pkg::DIV_CNT'(odp_pkg::DIV_W - 1)) begin
            step  <= quo_next[odp_pkg::STEP_W-1:0];
            dvd   <= DVD_RECIP;
            dsr   <= {1'b0, quo_next[odp_pkg::STEP_W-1:0]};
            rem   <= '0;
            cnt   <= '0;
            state <= ST_RECIP;
          end else begin
            dvd <= quo_next;
            rem <= rem_next;
            cnt <= cnt + 1'b1;
          end
        end
        ST_RECIP: begin
          if (cnt == odp_pkg::DIV_CNT'(odp_pkg::DIV_W - 1)) begin
            recip <= quo_next[odp_pkg::RECIP_W-1:0];
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            dvd <= quo_next;
            rem <= rem_next;
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready   = 1'b1;
  assign scale.busy  = (state != ST_IDLE);
  assign scale.step  = step;
  assign scale.recip = recip;

endmodule

[rtl/odp_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odp_pipe
// Five-stage dither datapath: threshold lookup, scaled add, reciprocal
// quotient, remainder, correction and saturation.
// ----------------------------------------------------------------------------
module odp_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  odp_pkg::scale_t               scale,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [odp_pkg::PIX_W-1:0]     in_pixel,
  input  logic [1:0]                    in_col,
  input  logic [1:0]                    in_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [odp_pkg::PIX_W-1:0]     out_pixel
);

  localparam int PROD_W = odp_pkg::SUM_W + odp_pkg::RECIP_W;

  // Stage valids and advance enables
  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  // Stage payloads
  logic [odp_pkg::PIX_W-1:0]  s1_pix;
  logic [odp_pkg::ENT_W-1:0]  s1_ent;
  logic [odp_pkg::SUM_W-1:0]  s2_sum;
  logic [odp_pkg::SUM_W-1:0]  s3_sum;
  logic [odp_pkg::SUM_W-1:0]  s3_quo;
  logic [odp_pkg::SUM_W-1:0]  s4_base;
  logic [odp_pkg::SUM_W-1:0]  s4_rem;
  logic [odp_pkg::PIX_W-1:0]  s5_out;

  logic [odp_pkg::STEP_W+odp_pkg::ENT_W-1:0] thr_prod;
  logic [odp_pkg::SUM_W-1:0]                 sum_next;
  logic [PROD_W-1:0]                         quo_prod;
  logic [odp_pkg::SUM_W+odp_pkg::STEP_W-1:0] base_prod;
  logic [odp_pkg::SUM_W-1:0]                 base_next;
  logic [odp_pkg::SUM_W-1:0]                 q_fix;

  // A stage moves when it is empty or its successor moves
  assign adv5     = !v5 || out_ready;
  assign adv4     = !v4 || adv5;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1 && !scale.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid && !scale.busy;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // Stage 2 logic: threshold = step * entry / 16, added to the pixel
  always_comb begin
    thr_prod = s1_ent * scale.step;
    sum_next = odp_pkg::SUM_W'(s1_pix) + odp_pkg::SUM_W'(thr_prod >> 4);
  end

  // Stage 3 logic: quotient estimate, equal to sum / step or one less
  assign quo_prod = s2_sum * scale.recip;

  // Stage 4 logic: the estimate times step and what is left of the sum
  always_comb begin
    base_prod = s3_quo * scale.step;
    base_next = base_prod[odp_pkg::SUM_W-1:0];
  end

  // Stage 5 logic: bump by one step when the estimate was low, then saturate
  assign q_fix = (s4_rem >= odp_pkg::SUM_W'(scale.step))
               ? s4_base + odp_pkg::SUM_W'(scale.step) : s4_base;

  // Hold payloads while stalled
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_pix <= in_pixel;
      s1_ent <= odp_pkg::bayer_entry(in_row, in_col);
    end
    if (adv2) begin
      s2_sum <= sum_next;
    end
    if (adv3) begin
      s3_sum <= s2_sum;
      s3_quo <= quo_prod[odp_pkg::RECIP_SHIFT +: odp_pkg::SUM_W];
    end
    if (adv4) begin
      s4_base <= base_next;
      s4_rem  <= s3_sum - base_next;
    end
    if (adv5) begin
      s5_out <= (q_fix > odp_pkg::SUM_W'(odp_pkg::PIX_MAX))
              ? odp_pkg::PIX_MAX : q_fix[odp_pkg::PIX_W-1:0];
    end
  end

  assign out_valid = v5;
  assign out_pixel = s5_out;

endmodule

[rtl/ordered_dither_pixel.sv]
`timescale 1ns / 1ps
// Throughput: one word per cycle, set by the five-stage datapath, while the
// output is ready and no level count write is in progress. After a write the
// input stalls while the serial divider derives the step and its reciprocal.
// Reset (synchronous, active high) loads level count 256 with its step and
// reciprocal ready, so words are taken right away.
// ----------------------------------------------------------------------------
// ordered_dither_pixel
// Ordered dither of one pixel with a 4x4 Bayer matrix and a configured
// number of output levels.
// ----------------------------------------------------------------------------
module ordered_dither_pixel (
  input  logic        clk,
  input  logic        rst,
  // Configuration: level count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [7:0] pixel_value, [19:8] column, [31:20] row
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] dithered_value
);

  odp_pkg::scale_t scale;

  // Step and reciprocal from the level count
  odp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .scale     (scale)
  );

  // Dither datapath; only the low two bits of column and row matter
  odp_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .scale     (scale),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pixel  (s_axis_tdata[7:0]),
    .in_col    (s_axis_tdata[9:8]),
    .in_row    (s_axis_tdata[21:20]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pixel (m_axis_tdata)
  );

endmodule
